// File: rtl/cmft_pkg.sv
// Package: widths, identifiers and constants for the motor feedback turn tracker.
`timescale 1ns / 1ps

package cmft_pkg;

    // number of lift motors tracked (1 to 4)
    localparam int LIFT_CHANNELS = 4;
    localparam int LIFT_IDX_W    = (LIFT_CHANNELS > 1) ? $clog2(LIFT_CHANNELS) : 1;

    localparam int ID_W    = 11;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int TURN_W  = 16;
    localparam int POS_W   = 20;
    localparam int CH_W    = 3;

    localparam logic [ID_W-1:0] ID_LIFT_BASE = 11'h201;
    localparam logic [ID_W-1:0] ID_YAW       = 11'h205;
    localparam logic [ID_W-1:0] ID_PITCH     = 11'h206;

    localparam logic [CH_W-1:0] CH_YAW   = 3'd4;
    localparam logic [CH_W-1:0] CH_PITCH = 3'd5;

    localparam logic [ANGLE_W-1:0] THRESH_RESET = 16'd5460;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    // 190*turns + angle spans about +-6.3e6: 24 bits signed, 23-bit magnitude
    localparam int SUM_W = 24;
    localparam int MAG_W = 23;

    // floor(n/1000) = (n * ceil(2^33/1000)) >> 33, exact for n < 2^23
    localparam int                RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;
    localparam int                RECIP_SHIFT = 33;
    localparam int                PROD_W      = MAG_W + RECIP_W;
    localparam int                QUOT_W      = 14;

    // sum of position parts before truncation to POS_W
    localparam int POS_SUM_W = POS_W + 1;

endpackage

// File: rtl/can_motor_feedback_turn_tracker.sv
// Top level: motor feedback decoder with multi-turn unwrap for the lift channels.
// Path: an accepted request moves through the stage 0, stage 1 and output registers in order to m_*.
// Throughput: one request per cycle while m_tready does not stall the output; the rate is set by the
//   per-channel turn update, a combinational read and registered write of the angle and turn registers in stage one.
// Reset (aresetn low, synchronous): pipeline emptied, stored angles and turn counts
//   cleared to zero, wrap_threshold set to 5460.
`timescale 1ns / 1ps

module can_motor_feedback_turn_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: wrap_threshold
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] angle_raw, [31:16] speed_raw
    input  logic [10:0] s_tuser,   // [10:0] frame_id
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] speed, [35:16] position, [39:36] zero
    output logic [3:0]  m_tuser    // [0] valid_res, [3:1] channel
);

    localparam int NL = cmft_pkg::LIFT_CHANNELS;
    localparam int IW = cmft_pkg::LIFT_IDX_W;

    // ---------------- configuration ----------------
    logic [cmft_pkg::ANGLE_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= cmft_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    // ---------------- pipeline handshake ----------------
    logic in_v_reg, mid_v_reg, out_v_reg;
    logic out_adv, mid_ready, in_ready;
    logic in_load, mid_load, out_load;

    assign out_adv   = !out_v_reg || m_tready;
    assign mid_ready = !mid_v_reg || out_adv;
    assign in_ready  = !in_v_reg || mid_ready;
    assign s_tready  = in_ready;

    assign in_load  = s_tvalid && in_ready;
    assign mid_load = in_v_reg && mid_ready;
    assign out_load = mid_v_reg && out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (in_ready)  in_v_reg  <= s_tvalid;
            if (mid_ready) mid_v_reg <= in_v_reg;
            if (out_adv)   out_v_reg <= mid_v_reg;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [cmft_pkg::ID_W-1:0]           in_id_reg;
    logic [cmft_pkg::ANGLE_W-1:0]        in_ang_reg;
    logic signed [cmft_pkg::SPEED_W-1:0] in_spd_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_id_reg  <= s_tuser;
            in_ang_reg <= s_tdata[15:0];
            in_spd_reg <= s_tdata[31:16];
        end
    end

    // ---------------- stage 1: decode and turn update ----------------
    logic [NL-1:0][cmft_pkg::ANGLE_W-1:0]       last_ang_reg;
    logic signed [NL-1:0][cmft_pkg::TURN_W-1:0] turns_reg;

    logic [cmft_pkg::ID_W:0]             id_ext;
    logic [cmft_pkg::ID_W-1:0]           lift_off;
    logic [IW-1:0]                       lift_idx;
    logic                                is_lift, is_yaw, is_pitch;
    logic [cmft_pkg::ANGLE_W-1:0]        last_ang;
    logic signed [cmft_pkg::TURN_W-1:0]  turn_cur, turn_new;
    logic [cmft_pkg::ANGLE_W:0]          last_plus_thr, ang_plus_thr;
    logic                                wrap_up, wrap_down;
    logic signed [cmft_pkg::SUM_W-1:0]   turn_ext, sum_val;
    logic                                sum_neg;
    logic [cmft_pkg::SUM_W-1:0]          sum_abs;

    assign id_ext   = {1'b0, in_id_reg};
    assign is_lift  = (in_id_reg >= cmft_pkg::ID_LIFT_BASE)
                   && (id_ext < ({1'b0, cmft_pkg::ID_LIFT_BASE} + (cmft_pkg::ID_W+1)'(NL)));
    assign is_yaw   = (in_id_reg == cmft_pkg::ID_YAW);
    assign is_pitch = (in_id_reg == cmft_pkg::ID_PITCH);
    assign lift_off = in_id_reg - cmft_pkg::ID_LIFT_BASE;
    assign lift_idx = lift_off[IW-1:0];

    assign last_ang = last_ang_reg[lift_idx];
    assign turn_cur = turns_reg[lift_idx];

    // last - new > thr  <=>  last > new + thr;  last - new < -thr  <=>  new > last + thr
    assign ang_plus_thr  = {1'b0, in_ang_reg} + {1'b0, thresh_reg};
    assign last_plus_thr = {1'b0, last_ang} + {1'b0, thresh_reg};
    assign wrap_up       = ({1'b0, last_ang} > ang_plus_thr);
    assign wrap_down     = ({1'b0, in_ang_reg} > last_plus_thr);

    always_comb begin
        turn_new = turn_cur;
        if (wrap_up) begin
            if (turn_cur != cmft_pkg::TURN_MAX) turn_new = turn_cur + 16'sd1;
        end else if (wrap_down) begin
            if (turn_cur != cmft_pkg::TURN_MIN) turn_new = turn_cur - 16'sd1;
        end
    end

    // 190*t = 128t + 64t - 2t
    assign turn_ext = {{(cmft_pkg::SUM_W-cmft_pkg::TURN_W){turn_new[cmft_pkg::TURN_W-1]}},
                       turn_new};
    assign sum_val  = (turn_ext <<< 7) + (turn_ext <<< 6) - (turn_ext <<< 1)
                    + $signed({{(cmft_pkg::SUM_W-cmft_pkg::ANGLE_W){1'b0}}, in_ang_reg});
    assign sum_neg  = sum_val[cmft_pkg::SUM_W-1];
    assign sum_abs  = sum_neg ? (~sum_val + 24'd1) : sum_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ang_reg <= '0;
            turns_reg    <= '0;
        end else if (mid_load && is_lift) begin
            last_ang_reg[lift_idx] <= in_ang_reg;
            turns_reg[lift_idx]    <= turn_new;
        end
    end

    logic                                mid_vres_reg, mid_lift_reg;
    logic [cmft_pkg::CH_W-1:0]           mid_ch_reg;
    logic signed [cmft_pkg::SPEED_W-1:0] mid_spd_reg;
    logic [cmft_pkg::ANGLE_W-1:0]        mid_ang_reg;
    logic signed [cmft_pkg::TURN_W-1:0]  mid_turn_reg;
    logic                                mid_neg_reg;
    logic [cmft_pkg::MAG_W-1:0]          mid_mag_reg;
    logic [cmft_pkg::CH_W-1:0]           ch_next;

    always_comb begin
        if (is_lift)       ch_next = {{(cmft_pkg::CH_W-IW){1'b0}}, lift_idx};
        else if (is_yaw)   ch_next = cmft_pkg::CH_YAW;
        else if (is_pitch) ch_next = cmft_pkg::CH_PITCH;
        else               ch_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (mid_load) begin
            mid_vres_reg <= is_lift || is_yaw || is_pitch;
            mid_lift_reg <= is_lift;
            mid_ch_reg   <= ch_next;
            mid_spd_reg  <= in_spd_reg;
            mid_ang_reg  <= in_ang_reg;
            mid_turn_reg <= turn_new;
            mid_neg_reg  <= sum_neg;
            mid_mag_reg  <= sum_abs[cmft_pkg::MAG_W-1:0];
        end
    end

    // ---------------- stage 2: divide by 1000 and assemble ----------------
    logic [cmft_pkg::PROD_W-1:0]           prod;
    logic [cmft_pkg::QUOT_W-1:0]           quot;
    logic signed [cmft_pkg::POS_SUM_W-1:0] quot_s, turn_x8, pos_sum;
    logic [cmft_pkg::POS_W-1:0]            pos_next;

    assign prod    = cmft_pkg::PROD_W'(mid_mag_reg) * cmft_pkg::PROD_W'(cmft_pkg::RECIP_1000);
    assign quot    = prod[cmft_pkg::RECIP_SHIFT +: cmft_pkg::QUOT_W];
    // truncation toward zero: divide the magnitude, then restore the sign
    assign quot_s  = mid_neg_reg
                   ? -$signed({{(cmft_pkg::POS_SUM_W-cmft_pkg::QUOT_W){1'b0}}, quot})
                   :  $signed({{(cmft_pkg::POS_SUM_W-cmft_pkg::QUOT_W){1'b0}}, quot});
    assign turn_x8 = {{(cmft_pkg::POS_SUM_W-cmft_pkg::TURN_W-3){mid_turn_reg[cmft_pkg::TURN_W-1]}},
                      mid_turn_reg, 3'b000};
    assign pos_sum = turn_x8 + quot_s;

    always_comb begin
        if (mid_lift_reg)      pos_next = pos_sum[cmft_pkg::POS_W-1:0];
        else if (mid_vres_reg) pos_next = {{(cmft_pkg::POS_W-cmft_pkg::ANGLE_W){1'b0}}, mid_ang_reg};
        else                   pos_next = '0;
    end

    logic                                out_vres_reg;
    logic [cmft_pkg::CH_W-1:0]           out_ch_reg;
    logic signed [cmft_pkg::SPEED_W-1:0] out_spd_reg;
    logic [cmft_pkg::POS_W-1:0]          out_pos_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_vres_reg <= mid_vres_reg;
            out_ch_reg   <= mid_ch_reg;
            out_spd_reg  <= mid_vres_reg ? mid_spd_reg : '0;
            out_pos_reg  <= pos_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0000, out_pos_reg, out_spd_reg};
    assign m_tuser  = {out_ch_reg, out_vres_reg};

    // ---------------- assertions ----------------
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tuser[3:1] == 3'd0) && (m_tdata == 40'd0))
        else $error("unknown identifier produced nonzero result");

    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tuser[3:1] <= cmft_pkg::CH_PITCH))
        else $error("channel out of range");

    a_raw_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && (m_tuser[3:1] >= cmft_pkg::CH_YAW)
        |-> (m_tdata[35:32] == 4'd0))
        else $error("yaw/pitch position is not a raw angle");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !mid_load |=> $stable(turns_reg) && $stable(last_ang_reg))
        else $error("turn state changed without a request moving");

    a_state_reset: assert property (@(posedge aclk)
        !aresetn |=> (turns_reg == '0) && !m_tvalid)
        else $error("reset did not clear turn state");

endmodule

// File: sim/cmft_feedback_checker.sv
// Checker for the motor feedback turn tracker: watches the input and result streams, predicts and compares.
`timescale 1ns / 1ps

module cmft_feedback_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [10:0] s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          error_count,
    output int          open_count,
    output int          checked_count
);

    localparam int TURN_POS_SCALE = 8;
    localparam int FRAC_NUM       = 190;
    localparam int FRAC_DEN       = 1000;

    typedef struct packed {
        logic                                valid_res;
        logic [cmft_pkg::CH_W-1:0]           channel;
        logic signed [cmft_pkg::SPEED_W-1:0] speed;
        logic signed [cmft_pkg::POS_W-1:0]   position;
    } feedback_result_t;

    logic [cmft_pkg::ANGLE_W-1:0] wrap_thr;
    logic [cmft_pkg::ANGLE_W-1:0] stored_angle [cmft_pkg::LIFT_CHANNELS];
    int                           turns        [cmft_pkg::LIFT_CHANNELS];
    feedback_result_t             pending_feedback [$];

    initial begin
        error_count   = 0;
        open_count    = 0;
        checked_count = 0;
    end

    // decode one frame and advance the lift channel state it selects
    function automatic feedback_result_t track_frame(
        logic [cmft_pkg::ID_W-1:0]           id,
        logic [cmft_pkg::ANGLE_W-1:0]        ang,
        logic signed [cmft_pkg::SPEED_W-1:0] spd);
        feedback_result_t r;
        int idx;
        int diff;
        int lim;
        int t;
        int pos;
        r = '0;
        if (id >= cmft_pkg::ID_LIFT_BASE
            && id < cmft_pkg::ID_LIFT_BASE + cmft_pkg::LIFT_CHANNELS) begin
            idx  = int'(id) - int'(cmft_pkg::ID_LIFT_BASE);
            diff = int'(stored_angle[idx]) - int'(ang);
            lim  = int'(wrap_thr);
            t    = turns[idx];
            if (diff > lim) begin
                if (t < int'(cmft_pkg::TURN_MAX)) t++;
            end else if (diff < -lim) begin
                if (t > int'(cmft_pkg::TURN_MIN)) t--;
            end
            turns[idx]        = t;
            stored_angle[idx] = ang;
            // SV integer division truncates toward zero
            pos          = t * TURN_POS_SCALE + (FRAC_NUM * t + int'(ang)) / FRAC_DEN;
            r.valid_res  = 1'b1;
            r.channel    = cmft_pkg::CH_W'(idx);
            r.speed      = spd;
            r.position   = pos[cmft_pkg::POS_W-1:0];
        end else if (id == cmft_pkg::ID_YAW) begin
            r.valid_res = 1'b1;
            r.channel   = cmft_pkg::CH_YAW;
            r.speed     = spd;
            r.position  = cmft_pkg::POS_W'(ang);
        end else if (id == cmft_pkg::ID_PITCH) begin
            r.valid_res = 1'b1;
            r.channel   = cmft_pkg::CH_PITCH;
            r.speed     = spd;
            r.position  = cmft_pkg::POS_W'(ang);
        end
        return r;
    endfunction

    function automatic void note_mismatch(string field, int want, int seen);
        if (want != seen) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        feedback_result_t want;
        feedback_result_t seen;
        if (!aresetn) begin
            wrap_thr = cmft_pkg::THRESH_RESET;
            for (int i = 0; i < cmft_pkg::LIFT_CHANNELS; i++) begin
                stored_angle[i] = '0;
                turns[i]        = 0;
            end
            pending_feedback.delete();
        end else begin
            if (cfg_we) wrap_thr = cfg_wdata;
            if (s_tvalid && s_tready)
                pending_feedback.push_back(track_frame(s_tuser, s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                seen.valid_res = m_tuser[0];
                seen.channel   = m_tuser[3:1];
                seen.speed     = m_tdata[15:0];
                seen.position  = m_tdata[35:16];
                if (pending_feedback.size() == 0) begin
                    $display("%0t ns: result with none expected, expected nothing, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = pending_feedback.pop_front();
                    note_mismatch("valid_res", want.valid_res, seen.valid_res);
                    note_mismatch("channel",   want.channel,   seen.channel);
                    note_mismatch("speed",     want.speed,     seen.speed);
                    note_mismatch("position",  want.position,  seen.position);
                end
                checked_count++;
            end
        end
        open_count = pending_feedback.size();
    end

endmodule

// File: sim/can_motor_feedback_turn_tracker_tb.sv
// Testbench top for the motor feedback turn tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module can_motor_feedback_turn_tracker_tb;

    localparam int RESULT_LATENCY = 2;
    localparam int PHASE_FRAMES   = 190;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [10:0] s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;

    int error_count;
    int open_count;
    int checked_count;
    int frames_sent  = 0;
    int thr_settings = 0;

    logic [cmft_pkg::ANGLE_W-1:0] walk_angle [cmft_pkg::LIFT_CHANNELS];

    can_motor_feedback_turn_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cmft_feedback_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .open_count    (open_count),
        .checked_count (checked_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: results still outstanding or input stuck");
        $display("== FAIL ==");
        $finish;
    end

    // sender gap state
    int  tx_calm_left = 0;
    bit  tx_calm      = 1'b0;

    task automatic send_frame(logic [cmft_pkg::ID_W-1:0] id, logic [cmft_pkg::ANGLE_W-1:0] ang,
                              logic [cmft_pkg::SPEED_W-1:0] spd);
        int gap;
        if (tx_calm_left == 0) begin
            tx_calm      = ($urandom_range(0, 2) == 0);
            tx_calm_left = $urandom_range(8, 48);
        end
        tx_calm_left--;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= id;
        s_tdata  <= {spd, ang};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frames_sent++;
    endtask

    // only while idle: every result back, then the pipeline given time to drain
    task automatic set_wrap_threshold(logic [15:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (open_count != 0) @(negedge aclk);
        repeat (RESULT_LATENCY + 2) @(negedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        thr_settings++;
    endtask

    task automatic random_frame();
        int                           pick;
        int                           ch;
        logic [cmft_pkg::ID_W-1:0]    id;
        logic [cmft_pkg::ANGLE_W-1:0] ang;
        pick = $urandom_range(0, 99);
        ch   = $urandom_range(0, cmft_pkg::LIFT_CHANNELS - 1);
        ang  = cmft_pkg::ANGLE_W'($urandom_range(0, 65535));
        if (pick < 65) begin
            // mostly a plausible rotation: moderate steps from the last angle
            if (pick < 55)
                ang = walk_angle[ch] + cmft_pkg::ANGLE_W'($urandom_range(0, 18000) - 9000);
            walk_angle[ch] = ang;
            id = cmft_pkg::ID_LIFT_BASE + cmft_pkg::ID_W'(ch);
        end else if (pick < 80) begin
            id = ($urandom_range(0, 1) == 0) ? cmft_pkg::ID_YAW : cmft_pkg::ID_PITCH;
        end else if (pick < 90) begin
            id = cmft_pkg::ID_LIFT_BASE - cmft_pkg::ID_W'(2)
               + cmft_pkg::ID_W'($urandom_range(0, 9));
        end else begin
            id = cmft_pkg::ID_W'($urandom_range(0, 2047));
        end
        send_frame(id, ang, cmft_pkg::SPEED_W'($urandom_range(0, 65535)));
    endtask

    // result side: stall a random number of cycles before each result
    initial begin : sink
        int rx_calm_left;
        bit rx_calm;
        int stall;
        rx_calm_left = 0;
        rx_calm      = 1'b0;
        forever begin
            if (rx_calm_left == 0) begin
                rx_calm      = ($urandom_range(0, 2) == 0);
                rx_calm_left = $urandom_range(8, 48);
            end
            rx_calm_left--;
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [15:0] thr_plan [6];
        for (int i = 0; i < cmft_pkg::LIFT_CHANNELS; i++) walk_angle[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: unknown ids, yaw/pitch extremes, wraps around the reset threshold
        send_frame(11'h000, 16'h0000, 16'h0000);
        send_frame(11'h7FF, 16'hFFFF, 16'hFFFF);
        send_frame(11'h200, 16'hAAAA, 16'h5555);
        send_frame(11'h207, 16'h5555, 16'hAAAA);
        send_frame(cmft_pkg::ID_YAW,   16'hFFFF, 16'h8000);
        send_frame(cmft_pkg::ID_PITCH, 16'h0000, 16'h7FFF);
        send_frame(cmft_pkg::ID_YAW,   16'h0000, 16'h0000);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd0,     16'd1);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd100,   16'd2);      // small step, no wrap
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd60100, 16'd3);      // down-count: negative turns
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd0,     16'hFFFF);   // up-count back to zero turns
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd65535, 16'd4);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd0,     16'd5);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd65000, 16'd6);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd60000, 16'd7);
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd54540, 16'd8);      // jump equal to threshold
        send_frame(cmft_pkg::ID_LIFT_BASE, 16'd49079, 16'd9);      // one past threshold
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd1, 16'd5461, 16'h8000);
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd1, 16'd0,    16'h7FFF);
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd2, 16'hFFFF, 16'h8000);
        // walk channel 2 down at turns -1 without a wrap, then a negative sum
        for (int a = 60535; a > 0; a -= 5000)
            send_frame(cmft_pkg::ID_LIFT_BASE + 11'd2, cmft_pkg::ANGLE_W'(a), 16'd10);
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd2, 16'd100, 16'd11);  // truncates toward zero
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd3, 16'h8000, 16'h7FFF);
        send_frame(cmft_pkg::ID_LIFT_BASE + 11'd3, 16'd27308, 16'h0000);
        send_frame(cmft_pkg::ID_PITCH, 16'hFFFF, 16'hFFFF);
        send_frame(11'h1FF, 16'hFFFF, 16'h7FFF);

        thr_plan = '{cmft_pkg::THRESH_RESET, 16'd0, 16'hFFFF, 16'd1, 16'd20000,
                     16'($urandom_range(0, 65535))};
        foreach (thr_plan[p]) begin
            set_wrap_threshold(thr_plan[p]);
            repeat (PHASE_FRAMES) random_frame();
        end

        set_wrap_threshold(cmft_pkg::THRESH_RESET);
        repeat (40) random_frame();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (open_count != 0) @(negedge aclk);
        repeat (RESULT_LATENCY + 8) @(negedge aclk);

        $display("Covered %0d feedback frames under %0d wrap thresholds, %0d results checked,",
                 frames_sent, thr_settings, checked_count);
        $display("with unknown ids, yaw/pitch pass-through and lift wraps both ways.");
        if (error_count == 0 && open_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/cmft_pkg.sv
rtl/can_motor_feedback_turn_tracker.sv
sim/cmft_feedback_checker.sv
sim/can_motor_feedback_turn_tracker_tb.sv
